// File: design/md5sh_pkg.sv
// md5sh_pkg: shared types, constants and helper functions of the MD5 stream hasher.
// Used by md5sh_buffer, md5sh_round and md5_stream_hasher_unit; no dependencies.
package md5sh_pkg;

   typedef struct packed {
      logic [31:0] a;
      logic [31:0] b;
      logic [31:0] c;
      logic [31:0] d;
   } md5sh_words_type;

   typedef struct packed {
      logic        byte_en;
      logic        len_en;
      logic [5:0]  pos;
      logic [7:0]  byte_val;
      logic [63:0] len;
   } md5sh_buf_wr_type;

   localparam logic [31:0] IvA = 32'h67452301;
   localparam logic [31:0] IvB = 32'hEFCDAB89;
   localparam logic [31:0] IvC = 32'h98BADCFE;
   localparam logic [31:0] IvD = 32'h10325476;

   localparam logic [7:0] PadMark   = 8'h80;
   localparam logic [7:0] PadZero   = 8'h00;
   localparam logic [5:0] LenPos    = 6'd56;
   localparam logic [5:0] LastPos   = 6'd63;
   localparam logic [5:0] LastRound = 6'd63;
   localparam logic [3:0] LenLoWord = 4'd14;
   localparam logic [3:0] LenHiWord = 4'd15;
   localparam logic [2:0] MaxBytes  = 3'd4;
   localparam logic [1:0] LastIndex = 2'd3;

   localparam logic [31:0] StepConst [64] = '{
      32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee,
      32'hf57c0faf, 32'h4787c62a, 32'ha8304613, 32'hfd469501,
      32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
      32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821,
      32'hf61e2562, 32'hc040b340, 32'h265e5a51, 32'he9b6c7aa,
      32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
      32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed,
      32'ha9e3e905, 32'hfcefa3f8, 32'h676f02d9, 32'h8d2a4c8a,
      32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
      32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70,
      32'h289b7ec6, 32'heaa127fa, 32'hd4ef3085, 32'h04881d05,
      32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
      32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039,
      32'h655b59c3, 32'h8f0ccc92, 32'hffeff47d, 32'h85845dd1,
      32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
      32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391
   };

   localparam logic [4:0] RotAmount [16] = '{
      5'd7, 5'd12, 5'd17, 5'd22, 5'd5, 5'd9, 5'd14, 5'd20,
      5'd4, 5'd11, 5'd16, 5'd23, 5'd6, 5'd10, 5'd15, 5'd21
   };

   function automatic logic [3:0] md5sh_g(input logic [5:0] step);
      logic [3:0] lo;
      logic [3:0] g;
      lo = step[3:0];
      unique case (step[5:4])
         2'd0: g = lo;
         2'd1: g = 4'(lo * 4'd5 + 4'd1);
         2'd2: g = 4'(lo * 4'd3 + 4'd5);
         2'd3: g = 4'(lo * 4'd7);
         default: g = lo;
      endcase
      return g;
   endfunction

   function automatic logic [31:0] md5sh_rotl(input logic [31:0] x, input logic [4:0] n);
      logic [63:0] w;
      w = {x, x} << n;
      return w[63:32];
   endfunction

endpackage

// File: design/md5_stream_hasher_unit.sv
// md5_stream_hasher_unit: MD5 hasher taking words of up to four message bytes.
// Each word is written into the block buffer byte by byte; each full block is compressed
// in 64 rounds and added to the chaining words. End of message adds padding, a second
// compression when the length spills, the length, a last compression and 4 digest words.
// Throughput: one word at a time; req_stall is high until the word is done.
// Reset (synchronous): chaining words to the MD5 initial values, length and position zero.
module md5_stream_hasher_unit (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [31:0] req_data_word,
   input  logic [2:0]  req_byte_count,
   input  logic        req_end_of_message,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [31:0] rsp_digest_word,
   output logic [1:0]  rsp_word_index,
   output logic        rsp_last_word
);
   import md5sh_pkg::*;

   typedef enum logic [6:0] {
      ST_IDLE  = 7'b0000001,
      ST_BYTE  = 7'b0000010,
      ST_PAD   = 7'b0000100,
      ST_LEN   = 7'b0001000,
      ST_ROUND = 7'b0010000,
      ST_FIN   = 7'b0100000,
      ST_OUT   = 7'b1000000
   } md5sh_state_type;

   md5sh_state_type  state_ff, state_in;
   md5sh_words_type  chain_ff, chain_in;
   md5sh_words_type  work_ff, work_in;
   md5sh_words_type  work_next;
   logic [63:0]      len_ff, len_in;
   logic [5:0]       pos_ff, pos_in;
   logic [5:0]       round_ff, round_in;
   logic [31:0]      data_ff, data_in;
   logic [2:0]       left_ff, left_in;
   logic             eom_ff, eom_in;
   logic             mark_ff, mark_in;
   logic             len_done_ff, len_done_in;
   logic [1:0]       idx_ff, idx_in;
   logic [2:0]       count;
   logic [3:0]       msg_index;
   logic [31:0]      msg_word;
   md5sh_buf_wr_type buf_wr;

   md5sh_buffer u_buffer (
      .clock    (clock),
      .wr       (buf_wr),
      .rd_index (msg_index),
      .rd_data  (msg_word)
   );

   md5sh_round u_round (
      .work      (work_ff),
      .step      (round_ff),
      .msg_word  (msg_word),
      .msg_index (msg_index),
      .work_next (work_next)
   );

   assign req_stall      = reset || (state_ff != ST_IDLE);
   assign rsp_valid      = (state_ff == ST_OUT);
   assign rsp_word_index = idx_ff;
   assign rsp_last_word  = (idx_ff == LastIndex);

   always_comb begin
      unique case (idx_ff)
         2'd0: rsp_digest_word = chain_ff.a;
         2'd1: rsp_digest_word = chain_ff.b;
         2'd2: rsp_digest_word = chain_ff.c;
         2'd3: rsp_digest_word = chain_ff.d;
         default: rsp_digest_word = chain_ff.a;
      endcase
   end

   always_comb begin
      state_in    = state_ff;
      chain_in    = chain_ff;
      work_in     = work_ff;
      len_in      = len_ff;
      pos_in      = pos_ff;
      round_in    = round_ff;
      data_in     = data_ff;
      left_in     = left_ff;
      eom_in      = eom_ff;
      mark_in     = mark_ff;
      len_done_in = len_done_ff;
      idx_in      = idx_ff;
      buf_wr      = '0;
      count       = (req_byte_count > MaxBytes) ? MaxBytes : req_byte_count;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               len_in  = len_ff + {58'd0, count, 3'b000};
               data_in = req_data_word;
               left_in = count;
               eom_in  = req_end_of_message;
               if (count != 3'd0) begin
                  state_in = ST_BYTE;
               end else if (req_end_of_message) begin
                  state_in = ST_PAD;
               end
            end
         end
         ST_BYTE: begin
            buf_wr.byte_en  = 1'b1;
            buf_wr.pos      = pos_ff;
            buf_wr.byte_val = data_ff[7:0];
            data_in = {8'd0, data_ff[31:8]};
            left_in = left_ff - 3'd1;
            pos_in  = pos_ff + 6'd1;
            if (pos_ff == LastPos) begin
               state_in = ST_ROUND;
               round_in = '0;
               work_in  = chain_ff;
            end else if (left_ff == 3'd1) begin
               state_in = eom_ff ? ST_PAD : ST_IDLE;
            end
         end
         ST_PAD: begin
            if (mark_ff && pos_ff == LenPos) begin
               state_in = ST_LEN;
            end else begin
               buf_wr.byte_en  = 1'b1;
               buf_wr.pos      = pos_ff;
               buf_wr.byte_val = mark_ff ? PadZero : PadMark;
               mark_in = 1'b1;
               pos_in  = pos_ff + 6'd1;
               if (pos_ff == LastPos) begin
                  state_in = ST_ROUND;
                  round_in = '0;
                  work_in  = chain_ff;
               end
            end
         end
         ST_LEN: begin
            buf_wr.len_en = 1'b1;
            buf_wr.len    = len_ff;
            len_done_in   = 1'b1;
            state_in      = ST_ROUND;
            round_in      = '0;
            work_in       = chain_ff;
         end
         ST_ROUND: begin
            work_in  = work_next;
            round_in = round_ff + 6'd1;
            if (round_ff == LastRound) begin
               state_in = ST_FIN;
            end
         end
         ST_FIN: begin
            chain_in.a = chain_ff.a + work_ff.a;
            chain_in.b = chain_ff.b + work_ff.b;
            chain_in.c = chain_ff.c + work_ff.c;
            chain_in.d = chain_ff.d + work_ff.d;
            priority if (len_done_ff) begin
               state_in = ST_OUT;
               idx_in   = '0;
            end else if (left_ff != 3'd0) begin
               state_in = ST_BYTE;
            end else if (eom_ff) begin
               state_in = ST_PAD;
            end else begin
               state_in = ST_IDLE;
            end
         end
         ST_OUT: begin
            if (!rsp_stall) begin
               idx_in = idx_ff + 2'd1;
               if (idx_ff == LastIndex) begin
                  chain_in    = '{a: IvA, b: IvB, c: IvC, d: IvD};
                  len_in      = '0;
                  pos_in      = '0;
                  eom_in      = 1'b0;
                  mark_in     = 1'b0;
                  len_done_in = 1'b0;
                  state_in    = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_IDLE;
         chain_ff    <= '{a: IvA, b: IvB, c: IvC, d: IvD};
         len_ff      <= '0;
         pos_ff      <= '0;
         round_ff    <= '0;
         left_ff     <= '0;
         eom_ff      <= 1'b0;
         mark_ff     <= 1'b0;
         len_done_ff <= 1'b0;
         idx_ff      <= '0;
      end else begin
         state_ff    <= state_in;
         chain_ff    <= chain_in;
         len_ff      <= len_in;
         pos_ff      <= pos_in;
         round_ff    <= round_in;
         left_ff     <= left_in;
         eom_ff      <= eom_in;
         mark_ff     <= mark_in;
         len_done_ff <= len_done_in;
         idx_ff      <= idx_in;
      end
   end

   always_ff @(posedge clock) begin
      work_ff <= work_in;
      data_ff <= data_in;
   end

   a_round_to_fin: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_ROUND && round_ff == LastRound) |=> (state_ff == ST_FIN))
      else $error("compression did not finish after the last step");

   a_len_at_pos: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_LEN) |-> (pos_ff == LenPos && mark_ff))
      else $error("length written at wrong position or before pad mark");

   a_out_after_len: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> len_done_ff)
      else $error("digest word shown before the length block was compressed");

   a_reinit: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_stall && rsp_last_word)
      |=> (state_ff == ST_IDLE && pos_ff == 6'd0 && len_ff == 64'd0))
      else $error("state not reinitialized after the digest");

endmodule

// File: design/md5sh_buffer.sv
// md5sh_buffer: 16-word message block buffer with byte writes and a length-word write.
// Depends on md5sh_pkg for the write request type and the length word indexes.
module md5sh_buffer (
   input  logic                        clock,
   input  md5sh_pkg::md5sh_buf_wr_type wr,
   input  logic [3:0]                  rd_index,
   output logic [31:0]                 rd_data
);
   import md5sh_pkg::*;

   logic [31:0] mem_ff [16];

   always_ff @(posedge clock) begin
      if (wr.byte_en) begin
         mem_ff[wr.pos[5:2]][{wr.pos[1:0], 3'b000} +: 8] <= wr.byte_val;
      end
      if (wr.len_en) begin
         mem_ff[LenLoWord] <= wr.len[31:0];
         mem_ff[LenHiWord] <= wr.len[63:32];
      end
   end

   assign rd_data = mem_ff[rd_index];

endmodule

// File: design/md5sh_round.sv
// md5sh_round: one MD5 step, shared over all 64 steps of a compression.
// Depends on md5sh_pkg for step constants, rotation table and message index function.
module md5sh_round (
   input  md5sh_pkg::md5sh_words_type work,
   input  logic [5:0]                 step,
   input  logic [31:0]                msg_word,
   output logic [3:0]                 msg_index,
   output md5sh_pkg::md5sh_words_type work_next
);
   import md5sh_pkg::*;

   logic [31:0] f;
   logic [31:0] t;

   assign msg_index = md5sh_g(step);

   always_comb begin
      unique case (step[5:4])
         2'd0: f = (work.b & work.c) | (~work.b & work.d);
         2'd1: f = (work.d & work.b) | (~work.d & work.c);
         2'd2: f = work.b ^ work.c ^ work.d;
         2'd3: f = work.c ^ (work.b | ~work.d);
         default: f = work.b ^ work.c ^ work.d;
      endcase
      t = work.a + f + StepConst[step] + msg_word;
      work_next.a = work.d;
      work_next.b = work.b + md5sh_rotl(t, RotAmount[{step[5:4], step[1:0]}]);
      work_next.c = work.b;
      work_next.d = work.c;
   end

endmodule
